@@ rtl/core/round_robin_thread_scheduler_macros.svh @@
// Assertion macros for the round-robin thread scheduler checker.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define RRTS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RRTS_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rrts_pkg.sv @@
// Types and constants shared by the round-robin thread scheduler files.
`default_nettype none

package rrts_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RSLOT_W  = 2;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = 32'd200;
  localparam logic [ID_W-1:0]   FIRST_ID      = 16'd1;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_YIELD   = 3'd1,
    OP_EXIT    = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4,
    OP_KILL    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NOT_RUNNING = 3'd1,
    STAT_NO_READY    = 3'd2,
    STAT_NOT_FOUND   = 3'd3,
    STAT_TABLE_FULL  = 3'd4,
    STAT_ALL_DONE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SL_FREE  = 3'd0,
    SL_RUN   = 3'd1,
    SL_READY = 3'd2,
    SL_SUSP  = 3'd3
  } slot_state_t;

  // What the slot scan is looking for.
  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_READY,
    SCAN_ID
  } scan_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_SCAN,
    S_UPD,
    S_FIN
  } fsm_t;

endpackage

`default_nettype wire

@@ rtl/core/rrts_if.sv @@
// Valid/ready channel interfaces for scheduler requests and responses.
`default_nettype none

interface sched_req_if import rrts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ID_W-1:0]     target_id;
  logic [TIME_W-1:0]   now_time;

  modport source (output valid, operation, target_id, now_time, input ready);
  modport sink   (input valid, operation, target_id, now_time, output ready);
endinterface

interface sched_rsp_if import rrts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RSLOT_W-1:0]  running_slot;
  logic [ID_W-1:0]     running_id;
  logic [ID_W-1:0]     created_id;
  logic                switched;

  modport source (output valid, status, running_slot, running_id, created_id, switched,
                  input ready);
  modport sink   (input valid, status, running_slot, running_id, created_id, switched,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/round_robin_thread_scheduler.sv @@
// Steps per request: S_CUR reads the current slot, S_SCAN walks the slot table, S_UPD updates it
// and S_FIN loads the response register; a kill of the running thread adds a second scan and update.
// The sequencer steps through the single slot read port one slot per cycle, and a new request is
// taken only in S_IDLE, once the last one is finished. Response waits in its own register.
// Reset (rst, synchronous): slot 0 running, other slots free, ids and start times zero,
// next id one, time quantum 200, no response pending.
`default_nettype none

module round_robin_thread_scheduler import rrts_pkg::*; #(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [TIME_W-1:0]   cfg_wdata,
  sched_req_if.sink                req,
  sched_rsp_if.source              rsp
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == IW'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  fsm_t state, state_next;

  logic [TIME_W-1:0]   time_quantum;
  slot_state_t         slot_state [SLOTS];
  logic [ID_W-1:0]     slot_id    [SLOTS];
  logic [TIME_W-1:0]   slot_start [SLOTS];
  logic [IW-1:0]       current;
  logic [ID_W-1:0]     next_id;

  logic [OP_W-1:0]     op_q;
  logic [ID_W-1:0]     tid_q;
  logic [TIME_W-1:0]   now_q;
  logic [IW-1:0]       before_q;
  status_t             status_q;
  logic [ID_W-1:0]     created_q;
  scan_mode_t          mode;
  logic [IW-1:0]       scan_idx;
  logic [CW-1:0]       left;
  logic                found;
  logic [IW-1:0]       hit_idx;
  slot_state_t         hit_state;

  logic                out_valid;
  status_t             out_status;
  logic [RSLOT_W-1:0]  out_slot;
  logic [ID_W-1:0]     out_run_id;
  logic [ID_W-1:0]     out_created;
  logic                out_switched;

  // single read port into the slot table
  logic [IW-1:0]       rd_idx;
  slot_state_t         rd_state;
  logic [ID_W-1:0]     rd_id;
  logic [TIME_W-1:0]   rd_start;
  logic [TIME_W-1:0]   elapsed;
  logic                cur_run, expired;
  logic                scan_hit, scan_last;
  logic                cur_scan;
  scan_mode_t          cur_mode;
  status_t             cur_status;
  logic                kill_restart;
  logic                out_load;

  assign rd_idx   = (state == S_SCAN) ? scan_idx : current;
  assign rd_state = slot_state[rd_idx];
  assign rd_id    = slot_id[rd_idx];
  assign rd_start = slot_start[rd_idx];
  assign elapsed  = now_q - rd_start;
  assign cur_run  = (rd_state == SL_RUN);
  assign expired  = (elapsed >= time_quantum);
  assign scan_last = (left == CW'(1));
  assign kill_restart = (op_q == OP_KILL) && found && (hit_state == SL_RUN);
  assign out_load = !out_valid || rsp.ready;

  always_comb begin
    unique case (mode)
      SCAN_FREE:  scan_hit = (rd_state == SL_FREE);
      SCAN_READY: scan_hit = (rd_state == SL_READY);
      SCAN_ID:    scan_hit = (rd_id == tid_q) && (op_q != OP_RESUME || rd_state == SL_SUSP);
      default:    scan_hit = 1'b0;
    endcase
  end

  // decision taken once the current slot has been read
  always_comb begin
    cur_scan   = 1'b0;
    cur_mode   = SCAN_READY;
    cur_status = STAT_OK;
    unique case (op_q)
      OP_CREATE: begin
        cur_scan = 1'b1;
        cur_mode = SCAN_FREE;
      end
      OP_YIELD: begin
        if (!cur_run) begin
          cur_status = STAT_NOT_RUNNING;
        end else if (expired) begin
          cur_scan = 1'b1;
        end
      end
      OP_EXIT: cur_scan = 1'b1;
      OP_SUSPEND: begin
        if (!cur_run) begin
          cur_status = STAT_NOT_RUNNING;
        end else begin
          cur_scan = 1'b1;
        end
      end
      OP_RESUME, OP_KILL: begin
        cur_scan = 1'b1;
        cur_mode = SCAN_ID;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = !rst;
        if (req.valid) state_next = S_CUR;
      end
      S_CUR:  state_next = cur_scan ? S_SCAN : S_FIN;
      S_SCAN: if (scan_hit || scan_last) state_next = S_UPD;
      S_UPD:  state_next = kill_restart ? S_SCAN : S_FIN;
      S_FIN:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum <= QUANTUM_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= (i == 0) ? SL_RUN : SL_FREE;
        slot_id[i]    <= '0;
        slot_start[i] <= '0;
      end
      current   <= '0;
      next_id   <= FIRST_ID;
      out_valid <= 1'b0;
      found     <= 1'b0;
      mode      <= SCAN_READY;
      scan_idx  <= '0;
      left      <= '0;
    end else begin
      if (cfg_we) time_quantum <= cfg_wdata;
      // a new beat loaded in S_FIN takes the place of the one leaving
      if (rsp.ready && state != S_FIN) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= req.operation;
            tid_q     <= req.target_id;
            now_q     <= req.now_time;
            before_q  <= current;
            created_q <= '0;
            found     <= 1'b0;
          end
        end
        S_CUR: begin
          if (cur_scan) begin
            mode <= cur_mode;
            unique case (cur_mode)
              SCAN_FREE: begin
                scan_idx <= IW'(1);
                left     <= CW'(SLOTS - 1);
              end
              SCAN_ID: begin
                scan_idx <= '0;
                left     <= CW'(SLOTS);
              end
              default: begin
                scan_idx <= wrap_inc(current);
                left     <= CW'(SLOTS - 1);
              end
            endcase
          end else begin
            status_q <= cur_status;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            found     <= 1'b1;
            hit_idx   <= scan_idx;
            hit_state <= rd_state;
          end else if (!scan_last) begin
            scan_idx <= wrap_inc(scan_idx);
            left     <= left - 1'b1;
          end
        end
        S_UPD: begin
          unique case (op_q)
            OP_CREATE: begin
              if (found) begin
                slot_state[hit_idx] <= SL_READY;
                slot_id[hit_idx]    <= next_id;
                slot_start[hit_idx] <= now_q;
                created_q           <= next_id;
                next_id             <= next_id + 1'b1;
                status_q            <= STAT_OK;
              end else begin
                status_q <= STAT_TABLE_FULL;
              end
            end
            OP_YIELD, OP_SUSPEND: begin
              if (found) begin
                slot_state[current] <= (op_q == OP_YIELD) ? SL_READY : SL_SUSP;
                slot_state[hit_idx] <= SL_RUN;
                slot_start[hit_idx] <= now_q;
                current             <= hit_idx;
                status_q            <= STAT_OK;
              end else begin
                status_q <= STAT_NO_READY;
              end
            end
            OP_EXIT: begin
              // the current slot is freed whether or not a successor exists
              slot_state[current] <= SL_FREE;
              if (found) begin
                slot_state[hit_idx] <= SL_RUN;
                slot_start[hit_idx] <= now_q;
                current             <= hit_idx;
                status_q            <= STAT_OK;
              end else begin
                status_q <= STAT_ALL_DONE;
              end
            end
            OP_RESUME: begin
              if (found) begin
                slot_state[hit_idx] <= SL_READY;
                status_q            <= STAT_OK;
              end else begin
                status_q <= STAT_NOT_FOUND;
              end
            end
            OP_KILL: begin
              if (!found || hit_state == SL_FREE) begin
                status_q <= STAT_NOT_FOUND;
              end else if (hit_state == SL_RUN) begin
                // killing the running thread is an exit: rescan for a successor
                op_q     <= OP_EXIT;
                found    <= 1'b0;
                mode     <= SCAN_READY;
                scan_idx <= wrap_inc(current);
                left     <= CW'(SLOTS - 1);
              end else begin
                slot_state[hit_idx] <= SL_FREE;
                status_q            <= STAT_OK;
              end
            end
            default: status_q <= STAT_OK;
          endcase
        end
        S_FIN: begin
          if (out_load) begin
            out_valid    <= 1'b1;
            out_status   <= status_q;
            out_slot     <= RSLOT_W'(current);
            out_run_id   <= rd_id;
            out_created  <= created_q;
            out_switched <= (current != before_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.running_slot = out_slot;
  assign rsp.running_id   = out_run_id;
  assign rsp.created_id   = out_created;
  assign rsp.switched     = out_switched;

endmodule

`default_nettype wire

@@ rtl/core/rrts_checker.sv @@
// Port-level checks for the round-robin thread scheduler, bound to the top level.
`default_nettype none
`include "round_robin_thread_scheduler_macros.svh"

module rrts_checker import rrts_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] rsp_status,
  input wire logic [ID_W-1:0]     rsp_created_id,
  input wire logic                rsp_switched
);

  `RRTS_ASSERT_RST(a_idle_after_reset, clk, rst |=> !rsp_valid, "response beat after reset")

  `RRTS_ASSERT(a_busy_after_req, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while busy")

  `RRTS_ASSERT(a_switch_ok, clk, rst, rsp_valid && rsp_switched |-> rsp_status == STAT_OK, "switch with failing status")

  `RRTS_ASSERT(a_full_quiet, clk, rst, rsp_valid && rsp_status == STAT_TABLE_FULL |-> rsp_created_id == '0 && !rsp_switched, "table full beat shows a change")

  `RRTS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "stalled response beat dropped")

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_created_id (rsp.created_id),
  .rsp_switched   (rsp.switched)
);

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the round-robin thread scheduler.
`default_nettype none

module tb import rrts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned SETTLE      = 16;      // beyond the worst-case request time
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t            status;
    logic [RSLOT_W-1:0] slot;
    logic [ID_W-1:0]    run_id;
    logic [ID_W-1:0]    new_id;
    logic               switched;
  } sched_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  sched_req_if req_if ();
  sched_rsp_if rsp_if ();

  round_robin_thread_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if.sink),
    .rsp       (rsp_if.source)
  );

  // Shadow copy of the thread table
  slot_state_t       tbl_state [SLOTS];
  logic [ID_W-1:0]   tbl_id    [SLOTS];
  logic [TIME_W-1:0] tbl_start [SLOTS];
  int unsigned       run_slot;
  logic [ID_W-1:0]   id_next;
  logic [TIME_W-1:0] quantum;

  sched_result_t outcomes_due [$];

  logic [TIME_W-1:0] sim_now = '0;

  int unsigned src_idle_pct = 8;
  int unsigned rcv_idle_pct = 85;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned beats_seen;
  int unsigned switches_seen;
  int unsigned quanta_set;
  int unsigned op_seen [6];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               outcomes_due.size());
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) rsp_if.ready <= !rst && ($urandom_range(99) >= rcv_idle_pct);

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Hands over to the first ready slot after the current one; -1 if none.
  function automatic int claim_ready(logic [TIME_W-1:0] t);
    int unsigned s;
    for (int k = 1; k < SLOTS; k++) begin
      s = (run_slot + k) % SLOTS;
      if (tbl_state[s] == SL_READY) begin
        tbl_state[s] = SL_RUN;
        tbl_start[s] = t;
        return s;
      end
    end
    return -1;
  endfunction

  function automatic status_t retire_current(logic [TIME_W-1:0] t);
    int nx;
    nx = claim_ready(t);
    tbl_state[run_slot] = SL_FREE;
    if (nx < 0) return STAT_ALL_DONE;
    run_slot = nx;
    return STAT_OK;
  endfunction

  function automatic sched_result_t schedule_outcome(op_t op, logic [ID_W-1:0] tid,
                                                     logic [TIME_W-1:0] t);
    sched_result_t     r;
    int unsigned       prev;
    int                nx;
    logic [TIME_W-1:0] held;
    bit                done;
    prev = run_slot;
    done = 1'b0;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_CREATE: begin
        r.status = STAT_TABLE_FULL;
        for (int s = 1; s < SLOTS && !done; s++) begin
          if (tbl_state[s] == SL_FREE) begin
            tbl_state[s] = SL_READY;
            tbl_id[s] = id_next;
            tbl_start[s] = t;
            r.new_id = id_next;
            id_next++;
            r.status = STAT_OK;
            done = 1'b1;
          end
        end
      end
      OP_YIELD: begin
        held = t - tbl_start[run_slot];
        if (tbl_state[run_slot] != SL_RUN) begin
          r.status = STAT_NOT_RUNNING;
        end else if (held >= quantum) begin
          nx = claim_ready(t);
          if (nx < 0) begin
            r.status = STAT_NO_READY;
          end else begin
            tbl_state[run_slot] = SL_READY;
            run_slot = nx;
          end
        end
      end
      OP_EXIT: r.status = retire_current(t);
      OP_SUSPEND: begin
        if (tbl_state[run_slot] != SL_RUN) begin
          r.status = STAT_NOT_RUNNING;
        end else begin
          nx = claim_ready(t);
          if (nx < 0) begin
            r.status = STAT_NO_READY;
          end else begin
            tbl_state[run_slot] = SL_SUSP;
            run_slot = nx;
          end
        end
      end
      OP_RESUME: begin
        r.status = STAT_NOT_FOUND;
        for (int s = 0; s < SLOTS && !done; s++) begin
          if (tbl_id[s] == tid && tbl_state[s] == SL_SUSP) begin
            tbl_state[s] = SL_READY;
            r.status = STAT_OK;
            done = 1'b1;
          end
        end
      end
      OP_KILL: begin
        r.status = STAT_NOT_FOUND;
        // first slot carrying the id decides, whatever its state
        for (int s = 0; s < SLOTS && !done; s++) begin
          if (tbl_id[s] == tid) begin
            done = 1'b1;
            if (tbl_state[s] == SL_RUN) begin
              r.status = retire_current(t);
            end else if (tbl_state[s] != SL_FREE) begin
              tbl_state[s] = SL_FREE;
              r.status = STAT_OK;
            end
          end
        end
      end
      default: ;
    endcase
    r.slot = run_slot[RSLOT_W-1:0];
    r.run_id = tbl_id[run_slot];
    r.switched = (run_slot != prev);
    return r;
  endfunction

  always @(posedge clk) begin : rsp_check
    sched_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      beats_seen++;
      if (rsp_if.switched === 1'b1) switches_seen++;
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("response beat %0d with nothing pending", beats_seen));
      end else begin
        want = outcomes_due.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("beat %0d status exp %0d got %0d", beats_seen,
                                    want.status, rsp_if.status));
        if (rsp_if.running_slot !== want.slot)
          report_mismatch($sformatf("beat %0d running_slot exp %0d got %0d", beats_seen,
                                    want.slot, rsp_if.running_slot));
        if (rsp_if.running_id !== want.run_id)
          report_mismatch($sformatf("beat %0d running_id exp %0h got %0h", beats_seen,
                                    want.run_id, rsp_if.running_id));
        if (rsp_if.created_id !== want.new_id)
          report_mismatch($sformatf("beat %0d created_id exp %0h got %0h", beats_seen,
                                    want.new_id, rsp_if.created_id));
        if (rsp_if.switched !== want.switched)
          report_mismatch($sformatf("beat %0d switched exp %0b got %0b", beats_seen,
                                    want.switched, rsp_if.switched));
      end
    end
  end

  // Valid is left high between back-to-back beats; it only drops for an idle gap.
  task automatic send_req(op_t op, logic [ID_W-1:0] tid, logic [TIME_W-1:0] t);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.target_id <= tid;
    req_if.now_time  <= t;
    do @(posedge clk); while (!req_if.ready);
    outcomes_due.push_back(schedule_outcome(op, tid, t));
    op_seen[int'(op)]++;
  endtask

  task automatic set_quantum(logic [TIME_W-1:0] q);
    req_if.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum = q;
    quanta_set++;
  endtask

  // Reset quantum: full table, quantum expiry, suspend/resume, kill paths, all finished.
  task automatic test_directed_lifecycle();
    send_req(OP_YIELD,   '0, 32'd0);      // within quantum
    send_req(OP_YIELD,   '0, 32'd300);    // expired, nobody ready
    send_req(OP_SUSPEND, '0, 32'd300);    // nobody ready
    repeat (3) send_req(OP_CREATE, '0, 32'd300);
    send_req(OP_CREATE,  '0, 32'd300);    // table full
    send_req(OP_YIELD,   '0, 32'd400);
    send_req(OP_YIELD,   '0, 32'd450);
    send_req(OP_SUSPEND, '0, 32'd450);
    send_req(OP_RESUME,  16'd1, 32'd460);
    send_req(OP_RESUME,  16'd1, 32'd460); // no longer suspended
    send_req(OP_KILL,    16'd3, 32'd470); // ready thread
    send_req(OP_KILL,    16'd3, 32'd470); // slot already free
    send_req(OP_KILL,    16'd2, 32'd480); // running thread
    send_req(OP_KILL,    16'd0, 32'd490); // boot thread in slot 0
    send_req(OP_EXIT,    '0, 32'd500);    // last one out
    send_req(OP_YIELD,   '0, 32'd510);    // current slot free
    send_req(OP_SUSPEND, '0, 32'd510);
    send_req(OP_KILL,    16'hFFFF, 32'd520);
    send_req(OP_CREATE,  '0, 32'd530);
    send_req(OP_YIELD,   '0, 32'd530);
  endtask

  // Quantum of zero and all ones, with timestamps across the 32-bit wrap.
  task automatic test_quantum_edges();
    set_quantum('0);
    send_req(OP_CREATE, '0, 32'hFFFF_FFF0);
    send_req(OP_CREATE, '0, 32'hFFFF_FFF0);
    send_req(OP_EXIT,   '0, 32'hFFFF_FFF0);
    send_req(OP_YIELD,  '0, 32'hFFFF_FFF0); // zero elapsed still switches
    set_quantum('1);
    send_req(OP_YIELD,  '0, tbl_start[run_slot] + 32'hFFFF_FFFE);
    send_req(OP_YIELD,  '0, tbl_start[run_slot] - 32'd1);
    set_quantum(QUANTUM_RESET);
  endtask

  task automatic test_random_mix(int unsigned n, int unsigned src_pct, int unsigned rcv_pct);
    op_t               op;
    logic [ID_W-1:0]   tid;
    logic [TIME_W-1:0] q;
    int unsigned       pick;
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(7))
          0:       q = '0;
          1:       q = '1;
          2:       q = $urandom();
          default: q = $urandom_range(20, 400);
        endcase
        set_quantum(q);
      end
      pick = $urandom_range(99);
      if (pick < 18)      op = OP_CREATE;
      else if (pick < 48) op = OP_YIELD;
      else if (pick < 58) op = OP_EXIT;
      else if (pick < 72) op = OP_SUSPEND;
      else if (pick < 86) op = OP_RESUME;
      else                op = OP_KILL;
      // mostly ids that sit in the table, some arbitrary
      if ($urandom_range(9) < 2) tid = ID_W'($urandom_range(16'hFFFF));
      else                       tid = tbl_id[$urandom_range(SLOTS-1)];
      case ($urandom_range(19))
        0:          sim_now = $urandom();
        1, 2, 3, 4: sim_now += $urandom_range(300, 1000);
        default:    sim_now += $urandom_range(0, 150);
      endcase
      send_req(op, tid, sim_now);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_CREATE;
    req_if.target_id   <= '0;
    req_if.now_time    <= '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_state[s] = SL_FREE;
      tbl_id[s]    = '0;
      tbl_start[s] = '0;
    end
    tbl_state[0] = SL_RUN;
    run_slot     = 0;
    id_next      = FIRST_ID;
    quantum      = QUANTUM_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_lifecycle();
    test_quantum_edges();
    test_random_mix(142, 8, 85);
    test_random_mix(142, 85, 8);
    test_random_mix(142, 0, 0);

    req_if.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests: create %0d, yield %0d, exit %0d, suspend %0d, resume %0d, kill %0d",
             beats_seen, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5]);
    $display("%0d thread switches seen under %0d quantum settings, %0d mismatches",
             switches_seen, quanta_set, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
